[rtl/s2u_pkg.sv]
// Shared types, codes and constants of the string to unsigned parser.
`default_nettype none

package s2u_pkg;

	localparam int S2U_INDEX_WIDTH = 16;
	localparam int QUEUE_DEPTH     = 2;

	localparam logic [5:0] BASE_MIN = 6'd2;
	localparam logic [5:0] BASE_MAX = 6'd36;
	localparam logic [5:0] BASE_OCT = 6'd8;
	localparam logic [5:0] BASE_DEC = 6'd10;
	localparam logic [5:0] BASE_HEX = 6'd16;
	localparam logic [5:0] BASE_AUTO = 6'd0;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LZ    = 8'h7a;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UZ    = 8'h5a;
	localparam logic [7:0] CH_LX    = 8'h78;
	localparam logic [7:0] CH_UX    = 8'h58;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0d;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_RANGE   = 2'd1;
	localparam logic [1:0] ST_BADBASE = 2'd2;

	localparam logic [15:0] STOP_MAX = 16'hffff;

	typedef struct packed {
		logic       begins;
		logic [7:0] ch;
	} s2u_in_t;

	typedef struct packed {
		logic [63:0] value;
		logic [1:0]  status;
		logic [15:0] stop_index;
	} s2u_out_t;

	// classified character, front to back
	typedef struct packed {
		logic        begins;
		logic        bad_base;
		logic [5:0]  base;
		logic        white;
		logic        plus;
		logic        minus;
		logic        zero;
		logic        xch;
		logic        alnum;
		logic [5:0]  dval;
		logic [15:0] stop;
	} s2u_cmd_t;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_LEAD,
		PH_SIGNED,
		PH_ZERO,
		PH_DIGITS
	} s2u_phase_t;

	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_ACC,
		ACT_OK,
		ACT_RANGE,
		ACT_BAD
	} s2u_act_t;

endpackage

`default_nettype wire

[rtl/s2u_front.sv]
// Front end: base register, position counter and character classification.
`default_nettype none

module s2u_front import s2u_pkg::*; #(
	parameter int INDEX_WIDTH = S2U_INDEX_WIDTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_wr,
	input  wire logic [5:0] cfg_data,
	input  wire logic       take,
	input  wire s2u_in_t    word,
	output s2u_cmd_t        cmd
);

	localparam logic [INDEX_WIDTH-1:0] POS_MAX = {INDEX_WIDTH{1'b1}};

	logic [5:0]             base_q;
	logic [INDEX_WIDTH-1:0] pos_q;
	logic [INDEX_WIDTH-1:0] pos_nxt;
	logic [31:0]            pos_ext;
	logic [7:0]             c;

	assign c = word.ch;

	always_comb begin
		if (word.begins) begin
			pos_nxt = '0;
		end else if (pos_q != POS_MAX) begin
			pos_nxt = pos_q + 1'b1;
		end else begin
			pos_nxt = pos_q;
		end
	end

	assign pos_ext = 32'(pos_nxt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_AUTO;
			pos_q  <= '0;
		end else begin
			if (cfg_wr) begin
				base_q <= cfg_data;
			end
			if (take) begin
				pos_q <= pos_nxt;
			end
		end
	end

	always_comb begin
		cmd          = '0;
		cmd.begins   = word.begins;
		cmd.base     = base_q;
		cmd.bad_base = (base_q != BASE_AUTO) && ((base_q < BASE_MIN) || (base_q > BASE_MAX));
		cmd.white    = (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
		cmd.plus     = (c == CH_PLUS);
		cmd.minus    = (c == CH_MINUS);
		cmd.zero     = (c == CH_ZERO);
		cmd.xch      = (c == CH_LX) || (c == CH_UX);
		cmd.stop     = (pos_ext > 32'(STOP_MAX)) ? STOP_MAX : pos_ext[15:0];
		if (c inside {[CH_ZERO:CH_NINE]}) begin
			cmd.alnum = 1'b1;
			cmd.dval  = 6'(c - CH_ZERO);
		end else if (c inside {[CH_LA:CH_LZ]}) begin
			cmd.alnum = 1'b1;
			cmd.dval  = 6'(c - CH_LA + 8'd10);
		end else if (c inside {[CH_UA:CH_UZ]}) begin
			cmd.alnum = 1'b1;
			cmd.dval  = 6'(c - CH_UA + 8'd10);
		end
	end

endmodule

`default_nettype wire

[rtl/s2u_queue.sv]
// Short queue of classified characters between front and back.
`default_nettype none

module s2u_queue import s2u_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire s2u_cmd_t push_cmd,
	input  wire logic     pop,
	output logic          full,
	output logic          empty,
	output s2u_cmd_t      head
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(QUEUE_DEPTH - 1);

	s2u_cmd_t        mem_q [QUEUE_DEPTH];
	logic [PW-1:0]   wr_q;
	logic [PW-1:0]   rd_q;
	logic [CW-1:0]   cnt_q;

	assign full  = (cnt_q == CW'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == LAST) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == LAST) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/s2u_back.sv]
// Back end: parse state machine, multiply-add accumulator and result register.
`default_nettype none

module s2u_back import s2u_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     q_empty,
	input  wire s2u_cmd_t cmd,
	output logic          pop,
	output logic          res_valid,
	input  wire logic     res_ready,
	output s2u_out_t      res_word
);

	s2u_phase_t  phase_q;
	s2u_phase_t  phase_nxt;
	s2u_phase_t  p0;
	s2u_act_t    act;
	logic [5:0]  base_q;
	logic [5:0]  base_nxt;
	logic [5:0]  b0;
	logic [5:0]  dig_base;
	logic        neg_q;
	logic        neg_nxt;
	logic [63:0] acc_q;
	logic [63:0] acc0;
	logic [63:0] acc_nxt;
	logic [69:0] prod;
	logic        dig_ok;
	logic        ovf;
	logic        emit;
	s2u_out_t    res_nxt;
	logic        out_valid_q;
	s2u_out_t    out_q;

	assign pop = !q_empty && (!out_valid_q || res_ready);

	assign p0       = cmd.begins ? PH_LEAD : phase_q;
	assign b0       = cmd.begins ? cmd.base : base_q;
	assign acc0     = cmd.begins ? 64'd0 : acc_q;
	assign dig_base = (b0 == BASE_AUTO) ? ((p0 == PH_ZERO) ? BASE_OCT : BASE_DEC) : b0;
	assign dig_ok   = cmd.alnum && (cmd.dval < dig_base);
	assign prod     = 70'(acc0) * 70'(dig_base) + 70'(cmd.dval);
	assign ovf      = |prod[69:64];

	// next state
	always_comb begin
		logic run;
		phase_nxt = p0;
		base_nxt  = b0;
		neg_nxt   = cmd.begins ? 1'b0 : neg_q;
		act       = ACT_NONE;
		run       = 1'b1;
		if (cmd.begins && cmd.bad_base) begin
			act       = ACT_BAD;
			phase_nxt = PH_IDLE;
			run       = 1'b0;
		end else if (!cmd.begins && phase_q == PH_IDLE) begin
			run = 1'b0;
		end
		if (run && phase_nxt == PH_LEAD) begin
			if (cmd.white) begin
				run = 1'b0;
			end else if (cmd.plus) begin
				phase_nxt = PH_SIGNED;
				run       = 1'b0;
			end else if (cmd.minus) begin
				neg_nxt   = 1'b1;
				phase_nxt = PH_SIGNED;
				run       = 1'b0;
			end else begin
				phase_nxt = PH_SIGNED;
			end
		end
		if (run && phase_nxt == PH_SIGNED) begin
			if ((base_nxt == BASE_AUTO || base_nxt == BASE_HEX) && cmd.zero) begin
				phase_nxt = PH_ZERO;
				run       = 1'b0;
			end else begin
				if (base_nxt == BASE_AUTO) begin
					base_nxt = BASE_DEC;
				end
				phase_nxt = PH_DIGITS;
			end
		end else if (run && phase_nxt == PH_ZERO) begin
			if (cmd.xch) begin
				base_nxt  = BASE_HEX;
				phase_nxt = PH_DIGITS;
				run       = 1'b0;
			end else begin
				if (base_nxt == BASE_AUTO) begin
					base_nxt = BASE_OCT;
				end
				phase_nxt = PH_DIGITS;
			end
		end
		if (run && phase_nxt == PH_DIGITS) begin
			if (!dig_ok) begin
				act       = ACT_OK;
				phase_nxt = PH_IDLE;
			end else if (ovf) begin
				act       = ACT_RANGE;
				phase_nxt = PH_IDLE;
			end else begin
				act = ACT_ACC;
			end
		end
	end

	// outputs
	always_comb begin
		acc_nxt            = acc0;
		emit               = 1'b0;
		res_nxt.value      = '0;
		res_nxt.status     = ST_OK;
		res_nxt.stop_index = cmd.stop;
		case (act)
			ACT_ACC: begin
				acc_nxt = prod[63:0];
			end
			ACT_OK: begin
				emit          = 1'b1;
				res_nxt.value = neg_nxt ? (64'd0 - acc0) : acc0;
			end
			ACT_RANGE: begin
				emit           = 1'b1;
				res_nxt.value  = '1;
				res_nxt.status = ST_RANGE;
			end
			ACT_BAD: begin
				emit               = 1'b1;
				res_nxt.status     = ST_BADBASE;
				res_nxt.stop_index = '0;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			base_q      <= BASE_AUTO;
			neg_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q <= phase_nxt;
				base_q  <= base_nxt;
				neg_q   <= neg_nxt;
			end
			if (pop && emit) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			acc_q <= acc_nxt;
		end
		if (pop && emit) begin
			out_q <= res_nxt;
		end
	end

	assign res_valid = out_valid_q;
	assign res_word  = out_q;

	a_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && emit) |=> (phase_q == PH_IDLE))
		else $error("phase not idle after a result");

	a_digit_base: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DIGITS) |-> (base_q >= BASE_MIN && base_q <= BASE_MAX))
		else $error("digit phase with unusable base");

	a_acc_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_LEAD || phase_q == PH_SIGNED || phase_q == PH_ZERO) |-> (acc_q == 64'd0))
		else $error("accumulator not clear before digits");

	a_badbase_word: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.status == ST_BADBASE) |->
		(out_q.value == 64'd0 && out_q.stop_index == 16'd0))
		else $error("bad base word carries data");

endmodule

`default_nettype wire

[rtl/string_to_unsigned_parser_top.sv]
// Top level of the streaming string to unsigned 64-bit parser.
// A result word is registered in the back end once the character that ends the numeral has left the queue.
// Throughput: one character per cycle while nothing stalls; the 64x6 multiply-add of the back end sets the cycle.
// The queue between front and back holds two characters; a held result stalls the back,
// and the input once the queue is full.
// Reset (arst_n low): parser idle, queue empty, no result pending, base register 0, position 0.
`default_nettype none

module string_to_unsigned_parser_top import s2u_pkg::*; #(
	parameter int INDEX_WIDTH = S2U_INDEX_WIDTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [5:0] cfg_data,
	input  wire logic       ch_valid,
	output logic            ch_ready,
	input  wire s2u_in_t    ch_word,
	output logic            res_valid,
	input  wire logic       res_ready,
	output s2u_out_t        res_word
);

	logic     q_full;
	logic     q_empty;
	logic     take;
	logic     pop;
	s2u_cmd_t cmd;
	s2u_cmd_t head;

	assign cfg_ready = 1'b1;
	assign ch_ready  = !q_full;
	assign take      = ch_valid && ch_ready;

	s2u_front #(
		.INDEX_WIDTH(INDEX_WIDTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_wr  (cfg_valid && cfg_ready),
		.cfg_data(cfg_data),
		.take    (take),
		.word    (ch_word),
		.cmd     (cmd)
	);

	s2u_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (take),
		.push_cmd(cmd),
		.pop     (pop),
		.full    (q_full),
		.empty   (q_empty),
		.head    (head)
	);

	s2u_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.cmd      (head),
		.pop      (pop),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_word (res_word)
	);

endmodule

`default_nettype wire

[test/string_to_unsigned_parser_top_tb.sv]
// Self-checking testbench for the streaming string to unsigned parser: directed table, then random strings.
`timescale 1ns / 1ps

module string_to_unsigned_parser_top_tb;
	import s2u_pkg::*;

	localparam int unsigned RANDOM_ITEMS   = 1250;
	localparam int unsigned HOLD_CYCLES    = 400;
	localparam int unsigned WATCHDOG_LIMIT = 4000;
	localparam int unsigned DRAIN_CYCLES   = 10;
	localparam logic [7:0]  NOT_A_DIGIT    = 8'hff;
	localparam int          NUM_ROWS       = 31;

	typedef enum logic {ROW_CHAR, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t  kind;
		logic [5:0] base;
		logic       begins;
		logic [7:0] ch;
		logic       typed;
		s2u_out_t   want;
	} row_t;

	localparam s2u_out_t NO_WANT = '0;

	logic     clk;
	logic     arst_n;
	logic     cfg_valid;
	logic     cfg_ready;
	logic [5:0] cfg_data;
	logic     ch_valid;
	logic     ch_ready;
	s2u_in_t  ch_word;
	logic     res_valid;
	logic     res_ready;
	s2u_out_t res_word;

	// typed expectation travelling with the word on the input channel
	logic     item_typed;
	s2u_out_t item_want;

	// predictor state
	logic [5:0]  cfg_base = BASE_AUTO;
	s2u_phase_t  st_phase = PH_IDLE;
	logic        st_neg   = 1'b0;
	logic [5:0]  st_base  = BASE_AUTO;
	logic [63:0] st_acc   = '0;
	logic [15:0] st_pos   = '0;

	s2u_out_t    parsed_q[$];
	int unsigned mismatches = 0;
	int unsigned idle_cycles = 0;
	int unsigned chars_sent = 0;
	bit          no_gaps = 1'b0;
	bit          hold_req = 1'b0;
	logic        next_begins = 1'b1;

	row_t plan [NUM_ROWS] = '{
		'{ROW_CHAR, BASE_AUTO, 1'b0, "3", 1'b0, NO_WANT},
		'{ROW_CHAR, BASE_AUTO, 1'b1, "7", 1'b0, NO_WANT},
		'{ROW_CHAR, BASE_AUTO, 1'b0, 8'hff, 1'b1, '{64'd7, ST_OK, 16'd1}},
		'{ROW_CHAR, BASE_AUTO, 1'b1, "0", 1'b0, NO_WANT},
		'{ROW_CHAR, BASE_AUTO, 1'b0, "X", 1'b0, NO_WANT},
		'{ROW_CHAR, BASE_AUTO, 1'b0, "g", 1'b1, '{64'd0, ST_OK, 16'd2}},
		'{ROW_CHAR, BASE_AUTO, 1'b1, 8'h09, 1'b0, NO_WANT},
		'{ROW_CHAR, BASE_AUTO, 1'b0, "-", 1'b0, NO_WANT},
		'{ROW_CHAR, BASE_AUTO, 1'b0, "0", 1'b0, NO_WANT},
		'{ROW_CHAR, BASE_AUTO, 1'b0, "1", 1'b0, NO_WANT},
		'{ROW_CHAR, BASE_AUTO, 1'b0, "7", 1'b0, NO_WANT},
		'{ROW_CHAR, BASE_AUTO, 1'b0, " ", 1'b0, NO_WANT},
		'{ROW_CHAR, BASE_AUTO, 1'b0, "5", 1'b0, NO_WANT},
		'{ROW_CFG, 6'd1, 1'b0, 8'h00, 1'b0, NO_WANT},
		'{ROW_CHAR, BASE_AUTO, 1'b1, "5", 1'b1, '{64'd0, ST_BADBASE, 16'd0}},
		'{ROW_CFG, 6'd63, 1'b0, 8'h00, 1'b0, NO_WANT},
		'{ROW_CHAR, BASE_AUTO, 1'b1, 8'h00, 1'b1, '{64'd0, ST_BADBASE, 16'd0}},
		'{ROW_CFG, BASE_MAX, 1'b0, 8'h00, 1'b0, NO_WANT},
		'{ROW_CHAR, BASE_AUTO, 1'b1, "Z", 1'b0, NO_WANT},
		'{ROW_CHAR, BASE_AUTO, 1'b0, "z", 1'b0, NO_WANT},
		'{ROW_CHAR, BASE_AUTO, 1'b0, "Z", 1'b0, NO_WANT},
		'{ROW_CHAR, BASE_AUTO, 1'b0, "z", 1'b0, NO_WANT},
		'{ROW_CHAR, BASE_AUTO, 1'b0, "Z", 1'b0, NO_WANT},
		'{ROW_CHAR, BASE_AUTO, 1'b0, "z", 1'b0, NO_WANT},
		'{ROW_CHAR, BASE_AUTO, 1'b0, "Z", 1'b0, NO_WANT},
		'{ROW_CHAR, BASE_AUTO, 1'b0, "z", 1'b0, NO_WANT},
		'{ROW_CHAR, BASE_AUTO, 1'b0, "Z", 1'b0, NO_WANT},
		'{ROW_CHAR, BASE_AUTO, 1'b0, "z", 1'b0, NO_WANT},
		'{ROW_CHAR, BASE_AUTO, 1'b0, "Z", 1'b0, NO_WANT},
		'{ROW_CHAR, BASE_AUTO, 1'b0, "z", 1'b0, NO_WANT},
		'{ROW_CHAR, BASE_AUTO, 1'b0, "z", 1'b1, '{64'hffff_ffff_ffff_ffff, ST_RANGE, 16'd12}}
	};

	string_to_unsigned_parser_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.ch_valid  (ch_valid),
		.ch_ready  (ch_ready),
		.ch_word   (ch_word),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_word  (res_word)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic logic [7:0] digit_value(input logic [7:0] c);
		if (c >= CH_ZERO && c <= CH_NINE)
			return c - CH_ZERO;
		if (c >= CH_LA && c <= CH_LZ)
			return c - CH_LA + 8'd10;
		if (c >= CH_UA && c <= CH_UZ)
			return c - CH_UA + 8'd10;
		return NOT_A_DIGIT;
	endfunction

	function automatic bit is_space(input logic [7:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	task automatic parse_char(input s2u_in_t w, output bit emit, output s2u_out_t r);
		logic [7:0]  c;
		logic [5:0]  b;
		logic [7:0]  d;
		logic [71:0] wide;
		c = w.ch;
		emit = 1'b0;
		r = '0;
		if (w.begins) begin
			st_pos = '0;
			st_neg = 1'b0;
			st_acc = '0;
			st_base = cfg_base;
			if (cfg_base != BASE_AUTO && (cfg_base < BASE_MIN || cfg_base > BASE_MAX)) begin
				emit = 1'b1;
				r = '{64'd0, ST_BADBASE, 16'd0};
				st_phase = PH_IDLE;
				return;
			end
			st_phase = PH_LEAD;
		end else begin
			if (st_phase == PH_IDLE)
				return;
			if (st_pos != STOP_MAX)
				st_pos = st_pos + 16'd1;
		end
		if (st_phase == PH_LEAD) begin
			if (is_space(c))
				return;
			if (c == CH_PLUS) begin
				st_phase = PH_SIGNED;
				return;
			end
			if (c == CH_MINUS) begin
				st_neg = 1'b1;
				st_phase = PH_SIGNED;
				return;
			end
			st_phase = PH_SIGNED;
		end
		if (st_phase == PH_SIGNED) begin
			if ((st_base == BASE_AUTO || st_base == BASE_HEX) && c == CH_ZERO) begin
				st_phase = PH_ZERO;
				return;
			end
			if (st_base == BASE_AUTO)
				st_base = BASE_DEC;
			st_phase = PH_DIGITS;
		end else if (st_phase == PH_ZERO) begin
			if (c == CH_LX || c == CH_UX) begin
				st_base = BASE_HEX;
				st_phase = PH_DIGITS;
				return;
			end
			if (st_base == BASE_AUTO)
				st_base = BASE_OCT;
			st_acc = '0;
			st_phase = PH_DIGITS;
		end
		if (st_phase == PH_DIGITS) begin
			b = (st_base >= BASE_MIN && st_base <= BASE_MAX) ? st_base : BASE_DEC;
			d = digit_value(c);
			if (d >= {2'b00, b}) begin
				emit = 1'b1;
				r = '{st_neg ? 64'd0 - st_acc : st_acc, ST_OK, st_pos};
				st_phase = PH_IDLE;
				return;
			end
			wide = 72'(st_acc) * 72'(b) + 72'(d);
			if (wide[71:64] != '0) begin
				emit = 1'b1;
				r = '{64'hffff_ffff_ffff_ffff, ST_RANGE, st_pos};
				st_phase = PH_IDLE;
				return;
			end
			st_acc = wide[63:0];
		end
	endtask

	always @(posedge clk) begin : monitor
		bit       emit;
		s2u_out_t got;
		s2u_out_t want;
		bit       moved;
		moved = 1'b0;
		if (cfg_valid && cfg_ready) begin
			cfg_base = cfg_data;
			moved = 1'b1;
		end
		if (ch_valid && ch_ready) begin
			parse_char(ch_word, emit, got);
			if (item_typed)
				parsed_q.push_back(item_want);
			else if (emit)
				parsed_q.push_back(got);
			moved = 1'b1;
		end
		if (res_valid && res_ready) begin
			moved = 1'b1;
			if (parsed_q.size() == 0) begin
				$display("%0t: unexpected word: value %h status %0d stop %0d", $time,
					res_word.value, res_word.status, res_word.stop_index);
				mismatches++;
			end else begin
				want = parsed_q.pop_front();
				if (res_word.value !== want.value) begin
					$display("%0t: value expected %h actual %h", $time, want.value,
						res_word.value);
					mismatches++;
				end
				if (res_word.status !== want.status) begin
					$display("%0t: status expected %0d actual %0d", $time, want.status,
						res_word.status);
					mismatches++;
				end
				if (res_word.stop_index !== want.stop_index) begin
					$display("%0t: stop_index expected %0d actual %0d", $time,
						want.stop_index, res_word.stop_index);
					mismatches++;
				end
			end
		end
		idle_cycles = moved ? 0 : idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog, no transfer for %0d cycles, %0d words outstanding", $time,
				idle_cycles, parsed_q.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// result side
	initial begin
		int unsigned gap;
		res_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = no_gaps ? 0 : $urandom_range(0, 14);
			if (hold_req) begin
				gap = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (gap > 0) begin
				res_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			res_ready <= 1'b1;
			@(posedge clk);
			while (!(res_valid && res_ready))
				@(posedge clk);
		end
	end

	task automatic send_char(input logic b, input logic [7:0] c, input logic typed,
		input s2u_out_t want);
		int unsigned gap;
		gap = no_gaps ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			ch_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		ch_valid <= 1'b1;
		ch_word <= '{begins: b, ch: c};
		item_typed <= typed;
		item_want <= want;
		@(posedge clk);
		while (!ch_ready)
			@(posedge clk);
	endtask

	task automatic set_base(input logic [5:0] b);
		ch_valid <= 1'b0;
		while (parsed_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= b;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic put(input logic [7:0] c);
		send_char(next_begins, c, 1'b0, NO_WANT);
		next_begins = 1'b0;
		chars_sent++;
	endtask

	function automatic logic [7:0] white_char();
		return ($urandom_range(0, 5) == 0) ? CH_SPACE : CH_TAB + 8'($urandom_range(0, 4));
	endfunction

	function automatic logic [7:0] digit_char(input int unsigned v);
		if (v < 10)
			return CH_ZERO + 8'(v);
		return (($urandom_range(0, 1) == 1) ? CH_LA : CH_UA) + 8'(v - 10);
	endfunction

	function automatic logic [7:0] non_digit(input int unsigned eff);
		logic [7:0] c;
		c = 8'($urandom_range(0, 255));
		while (32'(digit_value(c)) < eff)
			c = 8'($urandom_range(0, 255));
		return c;
	endfunction

	function automatic int unsigned digits_to_overflow(input int unsigned eff);
		logic [71:0] v;
		int unsigned n;
		v = 72'd1;
		n = 0;
		while (v <= 72'h00_ffff_ffff_ffff_ffff) begin
			v = v * 72'(eff);
			n++;
		end
		return n;
	endfunction

	task automatic send_numeral(input logic [5:0] b);
		int unsigned eff;
		int unsigned n;
		int unsigned r;
		eff = (b >= BASE_MIN && b <= BASE_MAX) ? 32'(b) : 32'(BASE_DEC);
		next_begins = 1'b1;
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3)) put(white_char());
		r = $urandom_range(0, 3);
		if (r == 0)
			put(CH_PLUS);
		else if (r == 1)
			put(CH_MINUS);
		if (b == BASE_AUTO || b == BASE_HEX) begin
			r = $urandom_range(0, 3);
			if (r == 0) begin
				put(CH_ZERO);
				put(($urandom_range(0, 1) == 1) ? CH_LX : CH_UX);
				eff = 32'(BASE_HEX);
			end else if (r == 1) begin
				put(CH_ZERO);
				if (b == BASE_AUTO)
					eff = 32'(BASE_OCT);
			end
		end
		if ($urandom_range(0, 7) == 0)
			n = digits_to_overflow(eff) + $urandom_range(0, 2) - 1;
		else
			n = $urandom_range(0, 6);
		repeat (n)
			put(digit_char(($urandom_range(0, 3) == 0) ? eff - 1 : $urandom_range(0, eff - 1)));
		// sometimes no terminator: the next begins cuts the string off
		if ($urandom_range(0, 7) != 0)
			put(non_digit(eff));
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3)) put(8'($urandom_range(0, 255)));
	endtask

	task automatic send_noise();
		int unsigned n;
		n = $urandom_range(1, 8);
		for (int unsigned i = 0; i < n; i++) begin
			send_char((i == 0) || ($urandom_range(0, 3) == 0), 8'($urandom_range(0, 255)),
				1'b0, NO_WANT);
			chars_sent++;
		end
	endtask

	initial begin
		logic [5:0] first_bases [8];
		logic [5:0] b;
		int unsigned phase_no;
		int unsigned phase_end;
		first_bases = '{BASE_AUTO, 6'd63, BASE_MIN, BASE_MAX, BASE_HEX, 6'd1, BASE_OCT, BASE_DEC};
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		ch_valid = 1'b0;
		ch_word = '0;
		item_typed = 1'b0;
		item_want = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG)
				set_base(plan[i].base);
			else
				send_char(plan[i].begins, plan[i].ch, plan[i].typed, plan[i].want);
		end

		chars_sent = 0;
		phase_no = 0;
		while (chars_sent < RANDOM_ITEMS) begin
			if (phase_no < 8)
				b = first_bases[phase_no];
			else if ($urandom_range(0, 3) == 0)
				b = 6'($urandom_range(0, 63));
			else
				b = 6'($urandom_range(BASE_MIN, BASE_MAX));
			no_gaps = ($urandom_range(0, 3) == 0);
			set_base(b);
			if (phase_no == 2)
				hold_req = 1'b1;
			phase_end = chars_sent + $urandom_range(40, 100);
			while (chars_sent < phase_end) begin
				if ($urandom_range(0, 9) == 0)
					send_noise();
				else
					send_numeral(b);
			end
			phase_no++;
		end

		ch_valid <= 1'b0;
		while (parsed_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

[filelist.f]
rtl/s2u_pkg.sv
rtl/s2u_front.sv
rtl/s2u_queue.sv
rtl/s2u_back.sv
rtl/string_to_unsigned_parser_top.sv
test/string_to_unsigned_parser_top_tb.sv
